// File: rtl/tbp_pkg.sv
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types, sizes and counter arithmetic for the tournament predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

  // Table size is a power of two, so the table index is the low address bits.
  localparam int TABLE_ENTRIES = 2048;
  localparam int HISTORY_BITS  = 11;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int ADDR_W        = 32;
  localparam int COUNT_W       = 32;

  typedef logic [1:0]              ctr_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [HISTORY_BITS-1:0] hist_t;
  typedef logic [COUNT_W-1:0]      count_t;

  localparam ctr_t   CTR_RESET = 2'd3;
  localparam ctr_t   CTR_MAX   = 2'd3;
  localparam ctr_t   CTR_MIN   = 2'd0;
  localparam count_t COUNT_MAX = '1;

  // Outcome of one training step.
  typedef struct packed {
    logic pred;
    logic hit;
    logic pick_global;
    ctr_t lc_new;
    ctr_t cc_new;
    ctr_t gc_new;
  } train_t;

  function automatic ctr_t ctr_train(input ctr_t c, input logic up);
    ctr_t r;
    r = c;
    if (up) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_MIN) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

// File: rtl/tbp_ram.sv
// ----------------------------------------------------------------------------
// tbp_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Read returns the old word on a same-address write; the caller forwards.
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: rtl/tbp_train.sv
// ----------------------------------------------------------------------------
// tbp_train
// Prediction and counter update for one resolved branch.
// ----------------------------------------------------------------------------
module tbp_train (
  input  tbp_pkg::ctr_t   lc,
  input  tbp_pkg::ctr_t   cc,
  input  tbp_pkg::ctr_t   gc,
  input  logic            taken,
  output tbp_pkg::train_t res
);
  import tbp_pkg::*;

  logic lp;
  logic gp;
  logic agree;

  always_comb begin
    lp    = lc[1];
    gp    = gc[1];
    agree = (lp == gp);

    res.pick_global = !agree && cc[1];
    res.pred        = agree ? gp : (cc[1] ? gp : lp);
    res.hit         = (res.pred == taken);
    // Chooser moves toward whichever side was right, only on a disagreement.
    res.cc_new      = agree ? cc : ctr_train(cc, gp == taken);
    res.lc_new      = ctr_train(lc, taken);
    res.gc_new      = ctr_train(gc, taken);
  end

endmodule

// File: rtl/tournament_branch_predictor_core.sv
// ----------------------------------------------------------------------------
// tournament_branch_predictor_core
// Gshare/bimodal tournament predictor trained on resolved branches.
// ----------------------------------------------------------------------------
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------
//   in       | in_valid/in_ready   | branch_addr[31:0], taken
//   out      | out_valid/out_ready | predicted_taken, correct, used_global,
//            |                     | correct_count[31:0]
//
// One word per cycle sustained unless the output stalls; a result passes the
// RAM read register, then the output register. The tables live in two RAMs
// (bimodal+chooser, gshare), read on accept and written back as the training
// stage advances, forwarding a same-entry write-back. After reset a clearing
// pass over all 2048 entries loads every counter with 3 and holds in_ready
// low. An output stall holds the training stage and back-pressures the input.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tbp_pkg::ADDR_W-1:0]   branch_addr,
  input  logic                         taken,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         predicted_taken,
  output logic                         correct,
  output logic                         used_global,
  output logic [tbp_pkg::COUNT_W-1:0]  correct_count
);
  import tbp_pkg::*;

  // clearing pass
  logic clearing;
  idx_t clr_idx;

  // history and index generation
  hist_t history;
  idx_t  li_in;
  idx_t  gi_in;
  logic  accept;

  // training stage
  logic   s1_valid;
  logic   s1_adv;
  idx_t   s1_li;
  idx_t   s1_gi;
  logic   s1_taken;
  logic   fwd_l;
  logic   fwd_g;
  ctr_t   fwd_lc;
  ctr_t   fwd_cc;
  ctr_t   fwd_gc;
  logic [3:0] l_rdata;
  ctr_t   g_rdata;
  ctr_t   lc_eff;
  ctr_t   cc_eff;
  ctr_t   gc_eff;
  train_t tr;
  count_t hit_total;
  count_t hit_total_next;

  // RAM write ports
  logic       wb_en;
  logic       l_we;
  idx_t       l_waddr;
  logic [3:0] l_wdata;
  logic       g_we;
  idx_t       g_waddr;
  ctr_t       g_wdata;

  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !clearing && (!s1_valid || s1_adv);
  assign accept   = in_valid && in_ready;

  assign li_in = branch_addr[IDX_W-1:0];
  assign gi_in = IDX_W'(branch_addr ^ ADDR_W'(history));

  assign wb_en   = s1_valid && s1_adv;
  assign l_we    = clearing || wb_en;
  assign g_we    = clearing || wb_en;
  assign l_waddr = clearing ? clr_idx : s1_li;
  assign g_waddr = clearing ? clr_idx : s1_gi;
  assign l_wdata = clearing ? {CTR_RESET, CTR_RESET} : {tr.cc_new, tr.lc_new};
  assign g_wdata = clearing ? CTR_RESET : tr.gc_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + idx_t'(1);
      if (clr_idx == idx_t'(TABLE_ENTRIES - 1)) clearing <= 1'b0;
    end
  end

  tbp_ram #(.WIDTH(4), .DEPTH(TABLE_ENTRIES)) u_local_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .re    (accept),
    .raddr (li_in),
    .rdata (l_rdata)
  );

  tbp_ram #(.WIDTH(2), .DEPTH(TABLE_ENTRIES)) u_global_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .re    (accept),
    .raddr (gi_in),
    .rdata (g_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      history  <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        history  <= (history << 1) | hist_t'(taken);
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Capture a write-back that lands on the entry being read this edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_li    <= li_in;
      s1_gi    <= gi_in;
      s1_taken <= taken;
      fwd_l    <= wb_en && (s1_li == li_in);
      fwd_g    <= wb_en && (s1_gi == gi_in);
      fwd_lc   <= tr.lc_new;
      fwd_cc   <= tr.cc_new;
      fwd_gc   <= tr.gc_new;
    end
  end

  assign lc_eff = fwd_l ? fwd_lc : l_rdata[1:0];
  assign cc_eff = fwd_l ? fwd_cc : l_rdata[3:2];
  assign gc_eff = fwd_g ? fwd_gc : g_rdata;

  tbp_train u_train (
    .lc    (lc_eff),
    .cc    (cc_eff),
    .gc    (gc_eff),
    .taken (s1_taken),
    .res   (tr)
  );

  assign hit_total_next = (tr.hit && hit_total != COUNT_MAX) ?
                          hit_total + count_t'(1) : hit_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hit_total <= '0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
      if (s1_valid) hit_total <= hit_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_en) begin
      predicted_taken <= tr.pred;
      correct         <= tr.hit;
      used_global     <= tr.pick_global;
      correct_count   <= hit_total_next;
    end
  end

endmodule

// File: test/tbp_checker.sv
// ----------------------------------------------------------------------------
// tbp_checker
// Watches both channels of the tournament predictor, predicts every result
// from its own copy of the three counter tables, the history and the hit
// count, and compares each result word field by field in arrival order.
// ----------------------------------------------------------------------------
module tbp_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [tbp_pkg::ADDR_W-1:0]   branch_addr,
  input  logic                         taken,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         predicted_taken,
  input  logic                         correct,
  input  logic                         used_global,
  input  logic [tbp_pkg::COUNT_W-1:0]  correct_count,
  output int                           fail_count,
  output int                           outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  import tbp_pkg::*;

  typedef struct packed {
    logic   pred;
    logic   hit;
    logic   glob;
    count_t hits;
  } branch_result_t;

  ctr_t   gshare_tbl [TABLE_ENTRIES];
  ctr_t   bimodal_tbl[TABLE_ENTRIES];
  ctr_t   chooser_tbl[TABLE_ENTRIES];
  hist_t  ghist;
  count_t hit_cnt;

  branch_result_t result_q[$];
  int             taken_cnt = 0;
  int             seen_cnt  = 0;

  assign outstanding = taken_cnt - seen_cnt;

  function automatic ctr_t sat_step(input ctr_t c, input logic up);
    if (up) return (c == 2'd3) ? c : c + 2'd1;
    return (c == 2'd0) ? c : c - 2'd1;
  endfunction

  // Predict one branch, then train gshare and bimodal on its outcome, and the chooser on a disagreement.
  function automatic branch_result_t resolve_branch(input logic [ADDR_W-1:0] pc,
                                                    input logic tk);
    int unsigned    bi;
    int unsigned    gi;
    ctr_t           bc;
    ctr_t           gc;
    ctr_t           sc;
    logic           bp;
    logic           gp;
    branch_result_t r;
    bi = pc % TABLE_ENTRIES;
    gi = (pc ^ ADDR_W'(ghist)) % TABLE_ENTRIES;
    bc = bimodal_tbl[bi];
    gc = gshare_tbl[gi];
    sc = chooser_tbl[bi];
    bp = bc[1];
    gp = gc[1];
    r.glob = 1'b0;
    if (bp == gp) begin
      r.pred = gp;
    end else begin
      r.glob = sc[1];
      r.pred = sc[1] ? gp : bp;
      chooser_tbl[bi] = sat_step(sc, gp == tk);
    end
    gshare_tbl[gi]  = sat_step(gc, tk);
    bimodal_tbl[bi] = sat_step(bc, tk);
    ghist = {ghist[HISTORY_BITS-2:0], tk};
    r.hit = (r.pred == tk);
    if (r.hit && hit_cnt != COUNT_MAX) hit_cnt = hit_cnt + count_t'(1);
    r.hits = hit_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    int             errs;
    branch_result_t exp_r;
    errs = 0;
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        gshare_tbl[i]  = CTR_RESET;
        bimodal_tbl[i] = CTR_RESET;
        chooser_tbl[i] = CTR_RESET;
      end
      ghist   = '0;
      hit_cnt = '0;
      result_q.delete();
      taken_cnt  <= 0;
      seen_cnt   <= 0;
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) begin
        result_q.insert(result_q.size(), resolve_branch(branch_addr, taken));
        taken_cnt <= taken_cnt + 1;
      end
      if (out_valid && out_ready) begin
        seen_cnt <= seen_cnt + 1;
        if (result_q.size() == 0) begin
          $error("result word with no branch pending");
          errs++;
        end else begin
          exp_r = result_q.pop_front();
          if (predicted_taken !== exp_r.pred) begin
            $error("predicted_taken mismatch: expected %0d, actual %0d",
                   exp_r.pred, predicted_taken);
            errs++;
          end
          if (correct !== exp_r.hit) begin
            $error("correct mismatch: expected %0d, actual %0d", exp_r.hit, correct);
            errs++;
          end
          if (used_global !== exp_r.glob) begin
            $error("used_global mismatch: expected %0d, actual %0d",
                   exp_r.glob, used_global);
            errs++;
          end
          if (correct_count !== exp_r.hits) begin
            $error("correct_count mismatch: expected %0d, actual %0d",
                   exp_r.hits, correct_count);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives resolved branches into the tournament predictor: a directed opening
// on counter limits, address extremes and long histories, then biased,
// looping and random branch streams under three idle mixes, with a long
// output stall and a full drain. The checker beside the block does the
// prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import tbp_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 11;
  localparam int PHASE_ITEMS  = 640;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int POOL_SIZE    = 16;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [ADDR_W-1:0]  branch_addr = '0;
  logic               taken       = 1'b0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic               predicted_taken;
  logic               correct;
  logic               used_global;
  logic [COUNT_W-1:0] correct_count;

  int fail_count;
  int outstanding;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int cycles        = 0;

  logic [ADDR_W-1:0] hot_addr[POOL_SIZE];
  int                hot_bias[POOL_SIZE];
  logic [ADDR_W-1:0] loop_addr;
  int                loop_len;
  int                loop_pos;

  tournament_branch_predictor_core u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .branch_addr     (branch_addr),
    .taken           (taken),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .predicted_taken (predicted_taken),
    .correct         (correct),
    .used_global     (used_global),
    .correct_count   (correct_count)
  );

  tbp_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .branch_addr     (branch_addr),
    .taken           (taken),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .predicted_taken (predicted_taken),
    .correct         (correct),
    .used_global     (used_global),
    .correct_count   (correct_count),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tournament_branch_predictor_core test failed");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_branch(input logic [ADDR_W-1:0] pc, input logic tk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    branch_addr <= pc;
    taken       <= tk;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hot branches with a fixed bias; some odd entries alias the table index of
  // their neighbor so that entries are shared.
  task automatic fill_pool();
    int bias_sel;
    for (int i = 0; i < POOL_SIZE; i++) begin
      hot_addr[i] = $urandom;
      if (i % 2 == 1 && $urandom_range(1) == 1)
        hot_addr[i][IDX_W-1:0] = hot_addr[i-1][IDX_W-1:0];
      bias_sel = $urandom_range(3);
      hot_bias[i] = (bias_sel == 0) ? 3 : (bias_sel == 1) ? 97 :
                    (bias_sel == 2) ? 50 : 80;
    end
    loop_addr = $urandom;
    loop_len  = $urandom_range(8, 2);
    loop_pos  = 0;
  endtask

  task automatic next_branch();
    int                r;
    int                k;
    logic [ADDR_W-1:0] pc;
    logic              tk;
    r = $urandom_range(99);
    if (r < 55) begin
      k  = $urandom_range(POOL_SIZE - 1);
      pc = hot_addr[k];
      tk = ($urandom_range(99) < hot_bias[k]);
    end else if (r < 82) begin
      // loop branch: taken until the last trip, then fall through
      pc = loop_addr;
      tk = (loop_pos != loop_len - 1);
      loop_pos++;
      if (loop_pos == loop_len) begin
        loop_pos = 0;
        if ($urandom_range(9) == 0) loop_len = $urandom_range(8, 2);
      end
    end else begin
      pc = $urandom;
      tk = 1'($urandom_range(1));
    end
    send_branch(pc, tk);
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct,
                           input bit do_drain, input bit do_hold);
    send_idle_pct = snd_pct;
    recv_idle_pct <= rcv_pct;
    fill_pool();
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == PHASE_ITEMS / 2 && do_drain) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      if (i == PHASE_ITEMS / 3 && do_hold) hold_req <= hold_req + 1;
      next_branch();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // address extremes
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b0);
    // drive one bimodal entry to its floor and hold it there
    repeat (4) send_branch(32'h0000_07FF, 1'b0);
    // push against the ceiling
    repeat (3) send_branch(32'h0000_0005, 1'b1);
    send_branch(32'hAAAA_AAAA, 1'b1);
    send_branch(32'h5555_5555, 1'b0);
    // more outcomes than the history holds, alternating
    for (int i = 0; i < 12; i++) send_branch(32'h0000_0100, i[0]);

    run_phase(16, 82, 1'b1, 1'b0);
    run_phase(82, 16, 1'b0, 1'b0);
    run_phase(0, 0, 1'b0, 1'b1);
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tournament_branch_predictor_core test passed");
    end else begin
      $display("tournament_branch_predictor_core test failed");
    end
    $finish;
  end

endmodule
